// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the deframer modules.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold in every cycle outside reset.
`define UST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// A condition that must be followed in the next cycle by a consequence.
`define UST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ustd_pkg.sv =====
package ustd_pkg;

  // Field widths.
  localparam int SizeW = 33;
  localparam int OffW  = 9;

  // Header block layout.
  localparam int BlkBytes   = 512;
  localparam int SizeOff    = 124;
  localparam int SizeDigits = 11;
  localparam int TypeOff    = 156;
  localparam int MagicOff   = 257;

  // Characters that the header decoding looks for.
  localparam logic [7:0] ChrNul   = 8'h00;
  localparam logic [7:0] ChrZero  = 8'h30;
  localparam logic [7:0] ChrSeven = 8'h37;
  localparam logic [7:0] ChrFive  = 8'h35;
  localparam logic [7:0] ChrU     = 8'h75;

  // Result kinds.
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;
  localparam logic [1:0] KIND_TRUNC   = 2'd3;

  // Entry types.
  localparam logic [1:0] TYPE_REGULAR = 2'd0;
  localparam logic [1:0] TYPE_DIR     = 2'd1;
  localparam logic [1:0] TYPE_OTHER   = 2'd2;

  // One result item.
  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       etype;
    logic [SizeW-1:0] size;
    logic [7:0]       data;
    logic             last_of_file;
    logic             last_in_run;
  } res_t;

  // Results produced by one accepted byte, in order: first r0, then r1.
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// ===== hdl/ustd_core.sv =====
`include "assert_macros.svh"

module ustd_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  logic [7:0]    in_byte,
  input  logic          in_end,
  output ustd_pkg::push_t push
);

  typedef enum logic [1:0] {PH_HDR, PH_PAY, PH_SKIP, PH_DONE} phase_t;

  localparam int SizeW = ustd_pkg::SizeW;
  localparam int OffW  = ustd_pkg::OffW;

  phase_t           phase_r, phase_nxt;
  logic [OffW-1:0]  block_offset_r, block_offset_nxt;
  logic [SizeW-1:0] size_accum_r, size_accum_nxt;
  logic             size_stopped_r, size_stopped_nxt;
  logic             name_empty_r, name_empty_nxt;
  logic             magic_ok_r, magic_ok_nxt;
  logic [1:0]       type_code_r, type_code_nxt;
  logic [SizeW-1:0] payload_left_r, payload_left_nxt;
  logic [OffW-1:0]  pad_left_r, pad_left_nxt;

  logic             main_vld;
  ustd_pkg::res_t   main_res;
  logic             trunc_vld;
  ustd_pkg::res_t   trunc_res;

  // Walk one archive byte through the block state.
  always_comb begin
    phase_nxt        = phase_r;
    block_offset_nxt = block_offset_r;
    size_accum_nxt   = size_accum_r;
    size_stopped_nxt = size_stopped_r;
    name_empty_nxt   = name_empty_r;
    magic_ok_nxt     = magic_ok_r;
    type_code_nxt    = type_code_r;
    payload_left_nxt = payload_left_r;
    pad_left_nxt     = pad_left_r;
    main_vld         = 1'b0;
    main_res         = '0;
    trunc_vld        = 1'b0;
    trunc_res        = '0;

    case (phase_r)
      PH_HDR: begin
        // The first byte of a block opens a new header.
        if (block_offset_r == '0) begin
          name_empty_nxt   = (in_byte == ustd_pkg::ChrNul);
          size_accum_nxt   = '0;
          size_stopped_nxt = 1'b0;
          magic_ok_nxt     = 1'b0;
          type_code_nxt    = ustd_pkg::TYPE_REGULAR;
        end
        // Octal size digits, up to the first byte that is not a digit.
        if (block_offset_r >= OffW'(ustd_pkg::SizeOff) &&
            block_offset_r < OffW'(ustd_pkg::SizeOff + ustd_pkg::SizeDigits) &&
            !size_stopped_r) begin
          if (in_byte >= ustd_pkg::ChrZero && in_byte <= ustd_pkg::ChrSeven) begin
            size_accum_nxt = {size_accum_r[SizeW-4:0], in_byte[2:0]};
          end else begin
            size_stopped_nxt = 1'b1;
          end
        end
        if (block_offset_r == OffW'(ustd_pkg::TypeOff)) begin
          if (in_byte == ustd_pkg::ChrZero || in_byte == ustd_pkg::ChrNul) begin
            type_code_nxt = ustd_pkg::TYPE_REGULAR;
          end else if (in_byte == ustd_pkg::ChrFive) begin
            type_code_nxt = ustd_pkg::TYPE_DIR;
          end else begin
            type_code_nxt = ustd_pkg::TYPE_OTHER;
          end
        end
        if (block_offset_r == OffW'(ustd_pkg::MagicOff)) begin
          magic_ok_nxt = (in_byte == ustd_pkg::ChrU);
        end
        // The last byte of the block settles what the header yields.
        if (block_offset_r == OffW'(ustd_pkg::BlkBytes - 1)) begin
          block_offset_nxt = '0;
          if (name_empty_nxt) begin
            main_vld      = 1'b1;
            main_res.kind = ustd_pkg::KIND_END;
            phase_nxt     = PH_DONE;
          end else if (magic_ok_nxt) begin
            main_vld       = 1'b1;
            main_res.kind  = ustd_pkg::KIND_HEADER;
            main_res.etype = type_code_nxt;
            main_res.size  = size_accum_nxt;
            payload_left_nxt = size_accum_nxt;
            // Padding up to the next block boundary is the negated low bits.
            pad_left_nxt = OffW'(0) - size_accum_nxt[OffW-1:0];
            if (size_accum_nxt == '0) begin
              phase_nxt = PH_HDR;
            end else if (type_code_nxt == ustd_pkg::TYPE_REGULAR) begin
              phase_nxt = PH_PAY;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
        end else begin
          block_offset_nxt = block_offset_r + OffW'(1);
        end
      end
      PH_PAY: begin
        // Pass a file data byte and mark the final one.
        if (payload_left_r != '0) begin
          payload_left_nxt = payload_left_r - SizeW'(1);
        end
        main_vld              = 1'b1;
        main_res.kind         = ustd_pkg::KIND_PAYLOAD;
        main_res.data         = in_byte;
        main_res.last_of_file = (payload_left_nxt == '0);
        if (payload_left_nxt == '0) begin
          phase_nxt = (pad_left_r != '0) ? PH_SKIP : PH_HDR;
        end
      end
      PH_SKIP: begin
        // Drop payload first, then the padding.
        if (payload_left_r != '0) begin
          payload_left_nxt = payload_left_r - SizeW'(1);
        end else if (pad_left_r != '0) begin
          pad_left_nxt = pad_left_r - OffW'(1);
        end
        if (payload_left_nxt == '0 && pad_left_nxt == '0) begin
          phase_nxt = PH_HDR;
        end
      end
      PH_DONE: begin
        // Bytes after the end of the archive are ignored.
      end
      default: begin
        phase_nxt = PH_HDR;
      end
    endcase

    // The end of the stream inside a payload reports what is missing.
    if (in_end) begin
      if ((phase_nxt == PH_PAY || phase_nxt == PH_SKIP) && payload_left_nxt != '0) begin
        trunc_vld       = 1'b1;
        trunc_res.kind  = ustd_pkg::KIND_TRUNC;
        trunc_res.etype = type_code_nxt;
        trunc_res.size  = payload_left_nxt;
      end
    end

    main_res.last_in_run  = !trunc_vld;
    trunc_res.last_in_run = 1'b1;
  end

  // Order the results of this byte for the result queue.
  always_comb begin
    push.n  = take ? ({1'b0, main_vld} + {1'b0, trunc_vld}) : 2'd0;
    push.r0 = main_vld ? main_res : trunc_res;
    push.r1 = trunc_res;
  end

  // Block state; the end of the stream returns it to reset.
  always_ff @(posedge clk) begin
    if (!rst_n || (take && in_end)) begin
      phase_r        <= PH_HDR;
      block_offset_r <= '0;
      size_accum_r   <= '0;
      size_stopped_r <= 1'b0;
      name_empty_r   <= 1'b0;
      magic_ok_r     <= 1'b0;
      type_code_r    <= ustd_pkg::TYPE_REGULAR;
      payload_left_r <= '0;
      pad_left_r     <= '0;
    end else if (take) begin
      phase_r        <= phase_nxt;
      block_offset_r <= block_offset_nxt;
      size_accum_r   <= size_accum_nxt;
      size_stopped_r <= size_stopped_nxt;
      name_empty_r   <= name_empty_nxt;
      magic_ok_r     <= magic_ok_nxt;
      type_code_r    <= type_code_nxt;
      payload_left_r <= payload_left_nxt;
      pad_left_r     <= pad_left_nxt;
    end
  end

  // Two results only come from a truncation at the end of the stream.
  `UST_ASSERT(a_two_only_at_end, push.n != 2'd2 || in_end, "two results without stream end")
  // Once the archive has ended, bytes produce nothing.
  `UST_ASSERT(a_done_quiet, phase_r != PH_DONE || push.n == 2'd0, "result after end of archive")
  // Outside a header the block offset rests at zero.
  `UST_ASSERT(a_offset_rest, phase_r == PH_HDR || block_offset_r == '0,
              "block offset moved outside header")

endmodule

// ===== hdl/ustd_rq.sv =====
`include "assert_macros.svh"

module ustd_rq (
  input  logic            clk,
  input  logic            rst_n,
  input  ustd_pkg::push_t push,
  output logic            full,
  output logic            out_valid,
  input  logic            out_stall,
  output ustd_pkg::res_t  head
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = PtrW + 1;

  ustd_pkg::res_t  mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            pop;

  // A byte is taken only while room for two results remains.
  assign full      = (count_r > CntW'(Depth - 2));
  assign out_valid = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PtrW'(push.n);
    rd_ptr_nxt = rd_ptr_r + PtrW'(pop);
    count_nxt  = count_r + CntW'(push.n) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Result storage; only free slots are written.
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_r + PtrW'(1)] <= push.r1;
    end
  end

  // Results only arrive while two slots are free.
  `UST_ASSERT(a_room, push.n == 2'd0 || count_r <= CntW'(Depth - 2), "result queue overrun")
  // A waiting result is still there in the next cycle if it was not taken.
  `UST_ASSERT_NEXT(a_keep, out_valid && out_stall, out_valid && count_r >= $past(count_r),
                   "waiting result lost")

endmodule

// ===== hdl/ustar_stream_deframer.sv =====
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   in_stream_byte, in_stream_end
// out_     output     out_valid/out_stall out_result_kind, out_entry_type, out_entry_size,
//                                         out_payload_byte, out_last_of_file, out_last_in_run
//
// One archive byte is accepted per cycle while in_stall is low; its results enter a
// four-entry result queue on the same edge and are offered from the next cycle, one
// per cycle while out_stall is low. A byte that ends the stream inside a payload can
// give two results; the queue takes both at once, so with out_stall low a byte is still
// accepted in every cycle. in_stall rises while more than two results wait in the queue,
// i.e. when out_stall backs up. rst_n is synchronous and clears the block state and the
// queue; the end of the stream returns the block state to its reset values as well.
module ustar_stream_deframer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_stream_byte,
  input  logic                      in_stream_end,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_result_kind,
  output logic [1:0]                out_entry_type,
  output logic [ustd_pkg::SizeW-1:0] out_entry_size,
  output logic [7:0]                out_payload_byte,
  output logic                      out_last_of_file,
  output logic                      out_last_in_run
);

  logic            take;
  logic            full;
  ustd_pkg::push_t push;
  ustd_pkg::res_t  head;

  // Input requests are taken whenever the queue has room.
  assign in_stall = full;
  assign take     = in_valid && !full;

  ustd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_byte (in_stream_byte),
    .in_end  (in_stream_end),
    .push    (push)
  );

  ustd_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  // Spread the head of the queue over the result ports.
  assign out_result_kind  = head.kind;
  assign out_entry_type   = head.etype;
  assign out_entry_size   = head.size;
  assign out_payload_byte = head.data;
  assign out_last_of_file = head.last_of_file;
  assign out_last_in_run  = head.last_in_run;

endmodule

// ===== tb/tb_ustar_stream_deframer.sv =====
`timescale 1ns / 1ps

module tb_ustar_stream_deframer;

  localparam int SizeW       = ustd_pkg::SizeW;
  localparam int OffW        = ustd_pkg::OffW;
  localparam int StallPct    = 27;
  localparam int QuietLimit  = 4000;
  localparam int DrainCycles = 16;
  localparam logic [SizeW-1:0] SizeMax = '1;

  typedef enum logic [1:0] {PH_HEADER, PH_DATA, PH_SKIP, PH_DONE} walk_phase_t;

  // Follows the archive walk byte by byte and holds the records still due from the block.
  class archive_tracker;
    walk_phase_t      phase;
    logic [OffW-1:0]  offset;
    logic [SizeW-1:0] size_acc;
    logic             size_halt;
    logic             name_empty;
    logic             magic_seen;
    logic [1:0]       etype;
    logic [SizeW-1:0] left;
    logic [OffW-1:0]  pad;
    ustd_pkg::res_t   due[$];
    int               mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      phase      = PH_HEADER;
      offset     = '0;
      size_acc   = '0;
      size_halt  = 1'b0;
      name_empty = 1'b0;
      magic_seen = 1'b0;
      etype      = ustd_pkg::TYPE_REGULAR;
      left       = '0;
      pad        = '0;
    endfunction

    function void emit(logic [1:0] kind, logic [1:0] et, logic [SizeW-1:0] sz,
                       logic [7:0] data, logic lof);
      ustd_pkg::res_t r;
      r.kind         = kind;
      r.etype        = et;
      r.size         = sz;
      r.data         = data;
      r.last_of_file = lof;
      r.last_in_run  = 1'b0;
      due.push_back(r);
    endfunction

    // Notes one accepted archive byte and queues the records that it causes.
    function void take_byte(logic [7:0] b, logic fin);
      int first;
      first = due.size();
      case (phase)
        PH_HEADER: begin
          if (offset == 0) begin
            name_empty = (b == ustd_pkg::ChrNul);
            size_acc   = '0;
            size_halt  = 1'b0;
            magic_seen = 1'b0;
            etype      = ustd_pkg::TYPE_REGULAR;
          end
          // The octal size stops at the first byte that is not a digit from 0 to 7.
          if (offset >= ustd_pkg::SizeOff &&
              offset < ustd_pkg::SizeOff + ustd_pkg::SizeDigits && !size_halt) begin
            if (b >= ustd_pkg::ChrZero && b <= ustd_pkg::ChrSeven)
              size_acc = {size_acc[SizeW-4:0], b[2:0]};
            else size_halt = 1'b1;
          end
          if (offset == ustd_pkg::TypeOff) begin
            etype = (b == ustd_pkg::ChrZero || b == ustd_pkg::ChrNul) ? ustd_pkg::TYPE_REGULAR :
                    (b == ustd_pkg::ChrFive) ? ustd_pkg::TYPE_DIR : ustd_pkg::TYPE_OTHER;
          end
          if (offset == ustd_pkg::MagicOff) magic_seen = (b == ustd_pkg::ChrU);
          if (offset == ustd_pkg::BlkBytes - 1) begin
            offset = '0;
            if (name_empty) begin
              emit(ustd_pkg::KIND_END, ustd_pkg::TYPE_REGULAR, '0, 8'h00, 1'b0);
              phase = PH_DONE;
            end else if (magic_seen) begin
              emit(ustd_pkg::KIND_HEADER, etype, size_acc, 8'h00, 1'b0);
              left = size_acc;
              pad  = OffW'(0) - size_acc[OffW-1:0];
              if (left == 0) phase = PH_HEADER;
              else phase = (etype == ustd_pkg::TYPE_REGULAR) ? PH_DATA : PH_SKIP;
            end
          end else begin
            offset = offset + 1'b1;
          end
        end
        PH_DATA: begin
          if (left != 0) left = left - 1'b1;
          emit(ustd_pkg::KIND_PAYLOAD, ustd_pkg::TYPE_REGULAR, '0, b, left == 0);
          if (left == 0) phase = (pad != 0) ? PH_SKIP : PH_HEADER;
        end
        PH_SKIP: begin
          if (left != 0) left = left - 1'b1;
          else if (pad != 0) pad = pad - 1'b1;
          if (left == 0 && pad == 0) phase = PH_HEADER;
        end
        default: ;
      endcase
      // The end of the stream inside a payload reports what is missing, then starts afresh.
      if (fin) begin
        if ((phase == PH_DATA || phase == PH_SKIP) && left != 0)
          emit(ustd_pkg::KIND_TRUNC, etype, left, 8'h00, 1'b0);
        restart();
      end
      if (due.size() > first) due[due.size()-1].last_in_run = 1'b1;
    endfunction

    // Compares one accepted record with the oldest one due.
    function void match_record(ustd_pkg::res_t got);
      ustd_pkg::res_t want;
      if (due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected record at %0t: kind %0d type %0d size %0d data %02h lof %0b lir %0b",
                   $time, got.kind, got.etype, got.size, got.data, got.last_of_file,
                   got.last_in_run);
        return;
      end
      want = due.pop_front();
      if (got.kind !== want.kind || got.etype !== want.etype || got.size !== want.size ||
          got.data !== want.data || got.last_of_file !== want.last_of_file ||
          got.last_in_run !== want.last_in_run) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("record mismatch at %0t (expected/actual): kind %0d/%0d type %0d/%0d",
                   $time, want.kind, got.kind, want.etype, got.etype);
          $display("  size %0d/%0d data %02h/%02h lof %0b/%0b lir %0b/%0b",
                   want.size, got.size, want.data, got.data, want.last_of_file,
                   got.last_of_file, want.last_in_run, got.last_in_run);
        end
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_stream_byte = 8'h00;
  logic             in_stream_end = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       out_result_kind;
  logic [1:0]       out_entry_type;
  logic [SizeW-1:0] out_entry_size;
  logic [7:0]       out_payload_byte;
  logic             out_last_of_file;
  logic             out_last_in_run;

  archive_tracker tracker;
  logic [7:0]     arch[$];
  bit             steady = 1'b0;
  int             quiet = 0;

  ustar_stream_deframer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_stream_byte   (in_stream_byte),
    .in_stream_end    (in_stream_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_entry_type   (out_entry_type),
    .out_entry_size   (out_entry_size),
    .out_payload_byte (out_payload_byte),
    .out_last_of_file (out_last_of_file),
    .out_last_in_run  (out_last_in_run)
  );

  always #4 clk = ~clk;

  // Records are checked before the byte taken on the same edge, which cannot affect them.
  always @(posedge clk) begin
    ustd_pkg::res_t got;
    got.kind         = out_result_kind;
    got.etype        = out_entry_type;
    got.size         = out_entry_size;
    got.data         = out_payload_byte;
    got.last_of_file = out_last_of_file;
    got.last_in_run  = out_last_in_run;
    if (rst_n) begin
      if (out_valid && !out_stall) tracker.match_record(got);
      if (in_valid && !in_stall) tracker.take_byte(in_stream_byte, in_stream_end);
    end
  end

  // The receiver stalls at random, except in the steady stretch.
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < StallPct);
  end

  // Ends the run when no request moves on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [7:0] non_octal();
    logic [7:0] c;
    case ($urandom_range(0, 2))
      0: c = ustd_pkg::ChrNul;
      1: c = 8'h20;
      default: begin
        do c = 8'($urandom); while (c >= ustd_pkg::ChrZero && c <= ustd_pkg::ChrSeven);
      end
    endcase
    return c;
  endfunction

  function automatic void put_random(int n);
    for (int i = 0; i < n; i++) arch.push_back(8'($urandom));
  endfunction

  // Appends a header block; fewer than eleven digits are closed by a non-octal byte.
  function automatic void put_header(logic [7:0] name0, logic [SizeW-1:0] size, int digits,
                                     logic [7:0] tflag, logic [7:0] magic);
    logic [7:0] blk [ustd_pkg::BlkBytes];
    for (int i = 0; i < ustd_pkg::BlkBytes; i++) blk[i] = 8'($urandom);
    blk[0] = name0;
    for (int i = 0; i < digits; i++)
      blk[ustd_pkg::SizeOff + i] = ustd_pkg::ChrZero +
                                   8'((size >> (3 * (digits - 1 - i))) & 7);
    if (digits < ustd_pkg::SizeDigits) blk[ustd_pkg::SizeOff + digits] = non_octal();
    blk[ustd_pkg::TypeOff]  = tflag;
    blk[ustd_pkg::MagicOff] = magic;
    for (int i = 0; i < ustd_pkg::BlkBytes; i++) arch.push_back(blk[i]);
  endfunction

  // Appends the payload of an entry and the padding up to the next block boundary.
  function automatic void put_body(logic [SizeW-1:0] size);
    int n;
    n = int'(size) + ((ustd_pkg::BlkBytes - int'(size % ustd_pkg::BlkBytes)) %
                      ustd_pkg::BlkBytes);
    put_random(n);
  endfunction

  // Offers one byte as a request, idling at random beforehand outside the steady stretch.
  task automatic send_byte(logic [7:0] b, logic fin);
    while (!steady && $urandom_range(0, 99) < StallPct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_stream_byte <= b;
    in_stream_end  <= fin;
    do @(posedge clk); while (in_stall);
  endtask

  // Sends the built archive up to the cut, or whole, with the stream end on its last byte.
  task automatic send_archive(int cut);
    int last;
    last = (cut < 0 || cut >= arch.size()) ? arch.size() - 1 : cut;
    for (int i = 0; i <= last; i++) send_byte(arch[i], i == last);
    arch.delete();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.due.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [7:0] name0;
    logic [7:0] tflag;
    int         digits;
    tracker = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // A small entry of random type and size-field length, ending in its padding.
    // Now and then its name is empty, so the block ends the archive instead.
    name0  = ($urandom_range(0, 3) == 0) ? ustd_pkg::ChrNul : 8'h61;
    digits = $urandom_range(1, ustd_pkg::SizeDigits);
    case ($urandom_range(0, 3))
      0: tflag = ustd_pkg::ChrZero;
      1: tflag = ustd_pkg::ChrNul;
      2: tflag = ustd_pkg::ChrFive;
      default: tflag = 8'h32;
    endcase
    put_header(name0, 5, digits, tflag, ustd_pkg::ChrU);
    put_body(5);
    send_archive(ustd_pkg::BlkBytes + 7);
    // Hold the sender back until the block has delivered everything.
    drain();

    // A regular file of the largest size, sent with no idling on either side. The stream
    // ends after a few dozen data bytes, so the last byte gives a data record and a
    // truncation record together.
    steady = 1'b1;
    put_header(8'h69, SizeMax, ustd_pkg::SizeDigits, ustd_pkg::ChrZero, ustd_pkg::ChrU);
    put_random(60);
    send_archive(-1);
    steady = 1'b0;

    // The stream ends on a lone empty name byte.
    put_header(ustd_pkg::ChrNul, '0, ustd_pkg::SizeDigits, ustd_pkg::ChrZero,
               ustd_pkg::ChrU);
    send_archive(0);

    drain();
    repeat (DrainCycles) @(posedge clk);
    if (tracker.mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
